// ===== rtl/centered_binomial_sampler_defines.svh =====
// Assertion macros used by the checker file of the sampler.
`ifndef CENTERED_BINOMIAL_SAMPLER_DEFINES_SVH
`define CENTERED_BINOMIAL_SAMPLER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define CBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/cbs_pkg.sv =====
package cbs_pkg;

  // Width of a fully gathered group (seven bytes) and of the byte store.
  localparam int unsigned WordW  = 56;
  localparam int unsigned StoreW = 48;

  // Bytes per group in the gathering modes.
  localparam int unsigned GroupThree = 3;
  localparam int unsigned GroupSeven = 7;

  typedef enum logic [1:0] {
    EtaOne   = 2'd0,
    EtaTwo   = 2'd1,
    EtaThree = 2'd2,
    EtaSeven = 2'd3
  } eta_sel_e;

  // One unit of work for the back end: the mode and the bits to sample.
  typedef struct packed {
    eta_sel_e          eta;
    logic [WordW-1:0]  bits;
  } cbs_job_t;

  // A job slot with its valid flag, used on both sides of the queue.
  typedef struct packed {
    logic     valid;
    cbs_job_t job;
  } cbs_slot_t;

  function automatic eta_sel_e decode_eta(input logic [2:0] mode);
    eta_sel_e sel;
    case (mode)
      3'd1:    sel = EtaOne;
      3'd2:    sel = EtaTwo;
      3'd3:    sel = EtaThree;
      default: sel = EtaSeven;
    endcase
    return sel;
  endfunction

  function automatic logic [2:0] ones7(input logic [6:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      n = n + {2'b00, v[i]};
    end
    return n;
  endfunction

endpackage

// ===== rtl/cbs_channels.sv =====
interface cbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] random_byte;

  modport source (output valid, output random_byte, input ready);
  modport sink (input valid, input random_byte, output ready);
endinterface

interface cbs_sample_if;
  logic              valid;
  logic              ready;
  logic signed [3:0] sample;
  logic              last_in_run;

  modport source (output valid, output sample, output last_in_run, input ready);
  modport sink (input valid, input sample, input last_in_run, output ready);
endinterface

// ===== rtl/cbs_front.sv =====
module cbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  cbs_byte_if.sink          byte_i,
  input  logic              full_i,
  output cbs_pkg::cbs_slot_t push_o
);

  logic [2:0]                 eta_q, eta_d;
  logic [cbs_pkg::StoreW-1:0] gbytes_q, gbytes_d;
  logic [2:0]                 gcnt_q, gcnt_d;

  cbs_pkg::eta_sel_e         eta_sel;
  logic                      fire;
  logic                      direct;
  logic                      group_last;
  logic [cbs_pkg::WordW-1:0] word;

  assign eta_sel = cbs_pkg::decode_eta(eta_q);
  assign byte_i.ready = !full_i;
  assign fire = byte_i.valid && byte_i.ready;
  assign direct = (eta_sel == cbs_pkg::EtaOne) || (eta_sel == cbs_pkg::EtaTwo);

  assign word = {8'b0, gbytes_q}
              | (cbs_pkg::WordW'(byte_i.random_byte) << {gcnt_q, 3'b000});

  always_comb begin
    case (eta_sel)
      cbs_pkg::EtaThree: group_last = (gcnt_q == 3'(cbs_pkg::GroupThree - 1));
      cbs_pkg::EtaSeven: group_last = (gcnt_q == 3'(cbs_pkg::GroupSeven - 1));
      default:           group_last = 1'b1;
    endcase
  end

  always_comb begin
    push_o.valid    = fire && (direct || group_last);
    push_o.job.eta  = eta_sel;
    push_o.job.bits = direct ? cbs_pkg::WordW'(byte_i.random_byte) : word;
  end

  always_comb begin
    eta_d    = eta_q;
    gbytes_d = gbytes_q;
    gcnt_d   = gcnt_q;
    if (cfg_we_i) begin
      // Any write drops a partly gathered group.
      eta_d    = cfg_wdata_i;
      gbytes_d = '0;
      gcnt_d   = 3'd0;
    end else if (fire && !direct) begin
      if (group_last) begin
        gbytes_d = '0;
        gcnt_d   = 3'd0;
      end else begin
        gbytes_d = word[cbs_pkg::StoreW-1:0];
        gcnt_d   = gcnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q    <= 3'd1;
      gbytes_q <= '0;
      gcnt_q   <= 3'd0;
    end else begin
      eta_q    <= eta_d;
      gbytes_q <= gbytes_d;
      gcnt_q   <= gcnt_d;
    end
  end

endmodule

// ===== rtl/cbs_queue.sv =====
module cbs_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbs_pkg::cbs_slot_t push_i,
  output logic               full_o,
  output cbs_pkg::cbs_slot_t head_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cbs_pkg::cbs_job_t entries_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = entries_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/cbs_back.sv =====
module cbs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbs_pkg::cbs_slot_t head_i,
  output logic               pop_o,
  cbs_sample_if.source       sample_o
);

  logic                      busy_q, busy_d;
  cbs_pkg::eta_sel_e         eta_q, eta_d;
  logic [cbs_pkg::WordW-1:0] word_q, word_d;
  logic [1:0]                idx_q, idx_d;

  logic       out_fire;
  logic       last;
  logic [2:0] ones_a, ones_b;
  logic [3:0] diff;

  assign last = (eta_q == cbs_pkg::EtaTwo) ? (idx_q == 2'd1) : (idx_q == 2'd3);
  assign out_fire = sample_o.valid && sample_o.ready;
  // The next job loads in the cycle its predecessor's last sample leaves.
  assign pop_o = head_i.valid && (!busy_q || (out_fire && last));

  always_comb begin
    case (eta_q)
      cbs_pkg::EtaOne: begin
        ones_a = cbs_pkg::ones7({6'b0, word_q[0]});
        ones_b = cbs_pkg::ones7({6'b0, word_q[1]});
      end
      cbs_pkg::EtaTwo: begin
        ones_a = cbs_pkg::ones7({5'b0, word_q[1:0]});
        ones_b = cbs_pkg::ones7({5'b0, word_q[3:2]});
      end
      cbs_pkg::EtaThree: begin
        ones_a = cbs_pkg::ones7({4'b0, word_q[2:0]});
        ones_b = cbs_pkg::ones7({4'b0, word_q[5:3]});
      end
      default: begin
        ones_a = cbs_pkg::ones7(word_q[6:0]);
        ones_b = cbs_pkg::ones7(word_q[13:7]);
      end
    endcase
  end

  assign diff = {1'b0, ones_a} - {1'b0, ones_b};

  assign sample_o.valid       = busy_q;
  assign sample_o.sample      = diff;
  assign sample_o.last_in_run = last;

  always_comb begin
    busy_d = busy_q;
    eta_d  = eta_q;
    word_d = word_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      eta_d  = head_i.job.eta;
      word_d = head_i.job.bits;
      idx_d  = 2'd0;
    end else if (out_fire) begin
      if (last) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + 2'd1;
      // Move the next pair of bit groups down to the bottom of the word.
      case (eta_q)
        cbs_pkg::EtaOne:   word_d = word_q >> 2;
        cbs_pkg::EtaTwo:   word_d = word_q >> 4;
        cbs_pkg::EtaThree: word_d = word_q >> 6;
        default:           word_d = word_q >> 14;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    eta_q  <= eta_d;
    word_q <= word_d;
    idx_q  <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

// ===== rtl/centered_binomial_sampler.sv =====
// Centered binomial noise sampler. Random bytes enter on byte_i and signed
// samples from -7 to 7 leave on sample_o, one per cycle at most, with
// last_in_run set on the final sample of each byte's (or group's) run. With
// eta 1 a byte gives four samples and with eta 2 two samples. With eta 3
// each group of 3 bytes gives four samples. With eta 7 bytes are taken
// one per cycle while the job queue is not full, and each group of 7 bytes
// gives four samples. The back end emits one sample per cycle while the
// receiver is ready; a short job queue in front of it lets the next byte be
// taken while samples still drain. The byte that completes a group is written
// into the job queue, and its samples leave from the back end's word register.
// Writing eta_mode through cfg_we_i drops any partly gathered group; write it
// only when the block is idle.
module centered_binomial_sampler #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i,
  cbs_byte_if.sink     byte_i,
  cbs_sample_if.source sample_o
);

  cbs_pkg::cbs_slot_t push;
  cbs_pkg::cbs_slot_t head;
  logic               full;
  logic               pop;

  cbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_i),
    .full_i      (full),
    .push_o      (push)
  );

  cbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  cbs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .sample_o (sample_o)
  );

endmodule

// ===== rtl/cbs_checker.sv =====
`include "centered_binomial_sampler_defines.svh"

module cbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] out_sample_i,
  input logic       out_last_i
);

  // Every run holds at least two samples, so two last flags never follow
  // each other on back-to-back transfers.
  `CBS_ASSERT(a_run_len, clk_i, rst_ni, (out_valid_i && out_ready_i && out_last_i) ##1 (out_valid_i && out_ready_i) |-> !out_last_i)

  // A difference of two popcounts of at most seven bits never reaches -8.
  `CBS_ASSERT(a_range, clk_i, rst_ni, out_valid_i |-> (out_sample_i != 4'b1000))

  // A stalled sample holds until it is taken.
  `CBS_ASSERT(a_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_sample_i) && $stable(out_last_i)))

  // No item is offered while reset is asserted.
  `CBS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i)

endmodule

bind centered_binomial_sampler cbs_checker u_cbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (sample_o.valid),
  .out_ready_i  (sample_o.ready),
  .out_sample_i (sample_o.sample),
  .out_last_i   (sample_o.last_in_run)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit  = 300000;
  // Margin for samples still in the job queue and the back end after the last byte.
  localparam int unsigned SettleCycles = 12;

  typedef struct {
    logic signed [3:0] sample;
    logic              last_in_run;
  } noise_rec_t;

  // Tracks the sampler state and holds the samples still owed by the block.
  class noise_scoreboard;
    noise_rec_t  owed_q[$];
    logic [2:0]  eta_mode;
    logic [47:0] gathered;
    int unsigned gathered_cnt;
    int unsigned errors;

    function new();
      eta_mode     = 3'd1;
      gathered     = '0;
      gathered_cnt = 0;
      errors       = 0;
    endfunction

    // Any write drops a partly gathered group, even with an unchanged value.
    function void configure(logic [2:0] value);
      eta_mode     = value;
      gathered     = '0;
      gathered_cnt = 0;
    endfunction

    function logic [3:0] popcount_diff(logic [55:0] word, int pos, int eta);
      int lo_ones;
      int hi_ones;
      lo_ones = 0;
      hi_ones = 0;
      for (int i = 0; i < eta; i++) begin
        lo_ones += word[pos + i];
        hi_ones += word[pos + eta + i];
      end
      return 4'(lo_ones - hi_ones);
    endfunction

    function void push_run(logic [55:0] word, int eta, int count);
      noise_rec_t rec;
      for (int k = 0; k < count; k++) begin
        rec.sample      = popcount_diff(word, 2 * eta * k, eta);
        rec.last_in_run = (k == count - 1);
        owed_q.push_back(rec);
      end
    endfunction

    function void note_byte(logic [7:0] value);
      cbs_pkg::eta_sel_e sel;
      int unsigned       group_len;
      logic [55:0]       word;
      case (eta_mode)
        3'd1:    sel = cbs_pkg::EtaOne;
        3'd2:    sel = cbs_pkg::EtaTwo;
        3'd3:    sel = cbs_pkg::EtaThree;
        default: sel = cbs_pkg::EtaSeven;
      endcase
      if (sel == cbs_pkg::EtaOne) begin
        push_run({48'd0, value}, 1, 4);
      end else if (sel == cbs_pkg::EtaTwo) begin
        push_run({48'd0, value}, 2, 2);
      end else begin
        group_len = (sel == cbs_pkg::EtaThree) ? cbs_pkg::GroupThree : cbs_pkg::GroupSeven;
        if (gathered_cnt >= group_len) begin
          gathered_cnt = 0;
          gathered     = '0;
        end
        word = {8'd0, gathered} | (56'(value) << (8 * gathered_cnt));
        if (gathered_cnt + 1 < group_len) begin
          gathered     = word[47:0];
          gathered_cnt = gathered_cnt + 1;
        end else begin
          gathered     = '0;
          gathered_cnt = 0;
          if (sel == cbs_pkg::EtaThree) begin
            push_run(word & 56'hFFFFFF, 3, 4);
          end else begin
            push_run(word, 7, 4);
          end
        end
      end
    endfunction

    function void check_sample(logic signed [3:0] sample, logic last_in_run);
      noise_rec_t exp_rec;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected item: sample %0d last_in_run %0b",
                 $time, sample, last_in_run);
        errors++;
        return;
      end
      exp_rec = owed_q.pop_front();
      if (sample !== exp_rec.sample) begin
        $display("%0t: sample mismatch: expected %0d, actual %0d",
                 $time, exp_rec.sample, sample);
        errors++;
      end
      if (last_in_run !== exp_rec.last_in_run) begin
        $display("%0t: last_in_run mismatch: expected %0b, actual %0b",
                 $time, exp_rec.last_in_run, last_in_run);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_wdata_i;
  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned cycle_cnt;

  noise_scoreboard sb;

  cbs_byte_if   byte_if ();
  cbs_sample_if sample_if ();

  centered_binomial_sampler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_if),
    .sample_o    (sample_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = 3'd0;
    byte_if.valid         = 1'b0;
    byte_if.random_byte   = 8'd0;
    sample_if.ready       = 1'b0;
    src_idle              = 0;
    snk_idle              = 0;
    cycle_cnt             = 0;
    sb                    = new();
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure and checking of every accepted sample.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sample_if.valid && sample_if.ready) begin
        sb.check_sample(sample_if.sample, sample_if.last_in_run);
      end
      sample_if.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  task automatic send_byte(logic [7:0] value);
    while ($urandom_range(0, 99) < src_idle) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid       <= 1'b1;
    byte_if.random_byte <= value;
    do @(posedge clk_i); while (!byte_if.ready);
    sb.note_byte(value);
  endtask

  task automatic wait_for_samples();
    byte_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_eta(logic [2:0] value);
    wait_for_samples();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.configure(value);
  endtask

  function automatic logic [7:0] random_byte_value();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(logic [2:0] eta, int unsigned src_pct, int unsigned snk_pct,
                           int unsigned n_items, bit mid_pause);
    write_eta(eta);
    src_idle = src_pct;
    snk_idle = snk_pct;
    for (int i = 0; i < n_items; i++) begin
      if (mid_pause && i == n_items / 2) begin
        wait_for_samples();
      end
      send_byte(random_byte_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed items at the reset mode, eta 1.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);

    write_eta(3'd2);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'hFF);

    write_eta(3'd3);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    // A partial group followed by a write of the same mode must be dropped.
    send_byte(8'h5A);
    send_byte(8'hA5);
    write_eta(3'd3);
    send_byte(8'h07);
    send_byte(8'hE0);
    send_byte(8'h81);

    // Group extremes for eta 7: +7 then -7 on the first sample.
    write_eta(3'd7);
    send_byte(8'h7F);
    repeat (6) send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h3F);
    repeat (5) send_byte(8'hFF);

    // Random phases over all register values and idling profiles.
    run_phase(3'd1,  0,  0, 8, 1'b0);
    run_phase(3'd2, 63,  0, 8, 1'b0);
    run_phase(3'd3,  0, 63, 9, 1'b1);
    run_phase(3'd7, 36, 36, 7, 1'b0);
    run_phase(3'd0,  0,  0, 7, 1'b0);
    run_phase(3'd4, 63,  0, 7, 1'b0);
    run_phase(3'd5,  0, 63, 7, 1'b0);
    run_phase(3'd6, 36, 36, 7, 1'b1);
    run_phase(3'd1, 36, 36, 6, 1'b0);
    run_phase(3'd3,  0,  0, 6, 1'b0);

    wait_for_samples();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
